>>> rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// shared constants and types for the sliding window maximum block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swm_pkg;

	localparam int MAX_WIN_DEF = 64;
	localparam int DATA_W      = 32;
	localparam int CFG_W       = 7;

	localparam logic [CFG_W-1:0] WIN_RESET = CFG_W'(3);

	// per-cycle control broadcast along the cell row
	typedef struct packed {
		logic en;     // a transaction is taken this cycle
		logic fresh;  // no earlier sample in the sequence
	} cell_ctl_t;

endpackage

>>> rtl/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// one cell of the running maximum row: holds the maximum of the samples up
// to its own age and passes it on to the next cell
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_cell #(
	parameter int DATA_WIDTH = swm_pkg::DATA_W
) (
	input  logic                         clk,
	input  swm_pkg::cell_ctl_t           ctl,
	input  logic signed [DATA_WIDTH-1:0] sample,
	input  logic signed [DATA_WIDTH-1:0] prev_max,
	output logic signed [DATA_WIDTH-1:0] max_nxt,
	output logic signed [DATA_WIDTH-1:0] max_q
);
	import swm_pkg::*;

	// a fresh sequence makes every cell start from the new sample
	always_comb begin
		if (ctl.fresh || (prev_max < sample)) begin
			max_nxt = sample;
		end else begin
			max_nxt = prev_max;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			max_q <= max_nxt;
		end
	end

endmodule

>>> rtl/sliding_window_maximum.sv
// result: an accepted sample's result is on the output register in the next cycle
// throughput: one sample per cycle while out_ready does not stall, set by the single
// compare in each row cell; samples that give no result are taken at the same rate
// reset: window size returns to 3, sequence state and output valid clear at once
// cell contents are not reset; the first sample of a sequence overwrites them
// ----------------------------------------------------------------------------
// sliding_window_maximum
// maximum of the last window_size signed samples, built as a row of cells
// where cell j keeps the maximum of the samples aged 0..j
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_maximum #(
	parameter int MAX_WINDOW = swm_pkg::MAX_WIN_DEF,
	parameter int DATA_WIDTH = swm_pkg::DATA_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [swm_pkg::CFG_W-1:0]     window_size,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [DATA_WIDTH-1:0]  sample,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [DATA_WIDTH-1:0]  window_max,
	output logic                          last_res
);
	import swm_pkg::*;

	localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int EW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	logic [CFG_W-1:0] window_size_q;
	logic [EW-1:0]    wcfg_ext;
	logic [IDX_W-1:0] win_idx;
	logic [IDX_W-1:0] rd_idx;
	logic [CNT_W-1:0] cnt_q;
	logic             full_q;
	logic             nonempty_q;
	logic             accept;
	logic             emit;
	logic             out_valid_q;
	logic             last_res_q;
	cell_ctl_t        ctl;

	logic signed [DATA_WIDTH-1:0] window_max_q;
	logic signed [DATA_WIDTH-1:0] cell_nxt [MAX_WINDOW];
	logic signed [DATA_WIDTH-1:0] cell_q   [MAX_WINDOW];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WIN_RESET;
		end else if (cfg_valid) begin
			window_size_q <= window_size;
		end
	end

	// window size zero acts as one, sizes past the row length saturate
	assign wcfg_ext = EW'(window_size_q);
	always_comb begin
		if (window_size_q == '0) begin
			win_idx = '0;
		end else if (wcfg_ext >= EW'(MAX_WINDOW)) begin
			win_idx = IDX_W'(MAX_WINDOW - 1);
		end else begin
			win_idx = IDX_W'(wcfg_ext - EW'(1));
		end
	end

	// samples in the window grow by at most one per transaction, so samples
	// that fell out under a smaller window stay out when the window grows
	always_comb begin
		if (cnt_q >= CNT_W'(win_idx)) begin
			rd_idx = win_idx;
		end else begin
			rd_idx = IDX_W'(cnt_q);
		end
	end

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign ctl.en    = accept;
	assign ctl.fresh = !nonempty_q;

	genvar j;
	generate
		for (j = 0; j < MAX_WINDOW; j++) begin : g_cell
			if (j == 0) begin : g_head
				swm_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
					.clk      (clk),
					.ctl      (ctl),
					.sample   (sample),
					.prev_max (sample),
					.max_nxt  (cell_nxt[j]),
					.max_q    (cell_q[j])
				);
			end else begin : g_body
				swm_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
					.clk      (clk),
					.ctl      (ctl),
					.sample   (sample),
					.prev_max (cell_q[j-1]),
					.max_nxt  (cell_nxt[j]),
					.max_q    (cell_q[j])
				);
			end
		end
	endgenerate

	// window fills once the sample count reaches the window size; a last sample always gives a result
	assign emit = full_q || (cnt_q >= CNT_W'(win_idx)) || last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			full_q     <= 1'b0;
			nonempty_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				cnt_q      <= '0;
				full_q     <= 1'b0;
				nonempty_q <= 1'b0;
			end else begin
				cnt_q      <= CNT_W'(rd_idx) + CNT_W'(1);
				full_q     <= emit;
				nonempty_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			window_max_q <= cell_nxt[rd_idx];
			last_res_q   <= last;
		end
	end

	assign out_valid  = out_valid_q;
	assign window_max = window_max_q;
	assign last_res   = last_res_q;

`ifndef ASSERT_OFF
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> !nonempty_q && !full_q && (cnt_q == '0))
		else $error("sequence state not cleared after last transaction");

	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> out_valid && last_res)
		else $error("last transaction gave no result");

	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		nonempty_q |-> cell_q[MAX_WINDOW-1] >= cell_q[0])
		else $error("cell row maximum not monotonic");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_WINDOW))
		else $error("sample count past row length");
`endif

endmodule
